>>> hw/rtl/mssr_pkg.sv
`timescale 1ns / 1ps

package mssr_pkg;

    // Default width of the saturating error counter.
    localparam int ERROR_WIDTH_DEF = 16;

    // Fixed field widths.
    localparam int ADDR_W   = 3;
    localparam int SEG_W    = 7;
    localparam int CNT_W    = 4;
    localparam int SETTLE_W = 16;
    localparam int CHAR_W   = 7;
    localparam int ERROUT_W = 16;

    // Configuration port.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_ADDR_CONFIRM = 2'd0;
    localparam logic [1:0] REG_SEG_CONFIRM  = 2'd1;
    localparam logic [1:0] REG_SETTLE       = 2'd2;

    // Register reset values.
    localparam logic [CNT_W-1:0]    ADDR_CONFIRM_RST = 4'd4;
    localparam logic [CNT_W-1:0]    SEG_CONFIRM_RST  = 4'd4;
    localparam logic [SETTLE_W-1:0] SETTLE_RST       = 16'd25;

    // Scan addresses with a fixed role.
    localparam logic [ADDR_W-1:0] SYNC_ADDRESS    = 3'd5;
    localparam logic [ADDR_W-1:0] CHANNEL_ADDRESS = 3'd3;
    localparam logic [ADDR_W-1:0] ADDR_IDLE       = 3'd7;
    localparam logic [SEG_W-1:0]  SEGS_IDLE       = 7'h7F;

    // Result position of the channel indicator.
    localparam logic [1:0] POS_CHANNEL = 2'd3;

    // Character given when no pattern matches.
    localparam logic [CHAR_W-1:0] UNKNOWN_CHAR = 7'd63;

    localparam int ROM_SIZE = 31;

    // Lit pattern (bit 0 is segment a) and the character it shows.
    localparam logic [SEG_W-1:0] ROM_LIT [ROM_SIZE] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F,
        7'h77, 7'h7C, 7'h58, 7'h5E, 7'h79, 7'h71, 7'h6F, 7'h74, 7'h04, 7'h1E,
        7'h38, 7'h54, 7'h5C, 7'h73, 7'h67, 7'h50, 7'h6D, 7'h1C, 7'h6E, 7'h40,
        7'h00
    };
    localparam logic [CHAR_W-1:0] ROM_CHAR [ROM_SIZE] = '{
        7'd48, 7'd49, 7'd50, 7'd51, 7'd52, 7'd53, 7'd54, 7'd55, 7'd56, 7'd57,
        7'd65, 7'd98, 7'd99, 7'd100, 7'd69, 7'd70, 7'd103, 7'd104, 7'd105, 7'd74,
        7'd76, 7'd110, 7'd111, 7'd80, 7'd81, 7'd114, 7'd83, 7'd117, 7'd121, 7'd45,
        7'd0
    };

    // Display phase within one frame.
    typedef enum logic [2:0] {
        PH_SYNC = 3'd0,
        PH_DIG0 = 3'd1,
        PH_DIG1 = 3'd2,
        PH_DIG2 = 3'd3,
        PH_CHAN = 3'd4
    } phase_t;

    // Step of reading one position.
    typedef enum logic [1:0] {
        STEP_ADDR   = 2'd0,
        STEP_SETTLE = 2'd1,
        STEP_SEGS   = 2'd2
    } step_t;

    typedef struct packed {
        logic [CNT_W-1:0]    addr_confirm;
        logic [CNT_W-1:0]    seg_confirm;
        logic [SETTLE_W-1:0] settle;
    } cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] scan_address;
        logic [SEG_W-1:0]  segment_lines;
    } sample_t;

    typedef struct packed {
        logic [1:0]          position;
        logic [CHAR_W-1:0]   char_code;
        logic [2:0]          channel_number;
        logic                frame_end;
        logic [ERROUT_W-1:0] error_total;
    } result_t;

    // Look up the character for a lit pattern; the earliest entry wins.
    function automatic logic [CHAR_W-1:0] decode_pattern(input logic [SEG_W-1:0] lit);
        logic [CHAR_W-1:0] ch;
        ch = UNKNOWN_CHAR;
        for (int i = ROM_SIZE - 1; i >= 0; i--) begin
            if (ROM_LIT[i] == lit) begin
                ch = ROM_CHAR[i];
            end
        end
        return ch;
    endfunction

    // Confirmation threshold; zero behaves as one.
    function automatic logic [CNT_W-1:0] need(input logic [CNT_W-1:0] n);
        return (n == '0) ? CNT_W'(1) : n;
    endfunction

endpackage

>>> hw/rtl/muxed_seven_segment_reader_unit.sv
`timescale 1ns / 1ps

// Reader for a multiplexed seven-segment display.
// Input channel (in_valid/in_ready): one sample of the scan address lines and
// the active-low segment lines per transaction. Output channel
// (out_valid/out_ready): one result per displayed digit (position 0 to 2 with
// its character) and one channel result (position 3) that closes a frame.
// Most samples give no result. Configuration goes through a small APB-style
// port: confirm counts for address and segments and the settle length.
// A sample is captured in an input register; when it advances, the frame
// tracker processes it and its result, if any, is loaded into the output
// register. Throughput is one sample per cycle while no result is stalled
// at the output; the tracker state update is combinational logic between
// the input and output registers.
// If the receiver stalls with a result pending, one further sample is held in
// the input register and in_ready then drops until the result is taken.
// Reset clears both registers and returns the tracker to waiting for the sync
// address with the error count at zero and the registers at their defaults.
module muxed_seven_segment_reader_unit
    import mssr_pkg::*;
#(
    parameter int ERROR_WIDTH = ERROR_WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ADDR_W-1:0]   scan_address,
    input  logic [SEG_W-1:0]    segment_lines,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          position,
    output logic [CHAR_W-1:0]   char_code,
    output logic [2:0]          channel_number,
    output logic                frame_end,
    output logic [ERROUT_W-1:0] error_total,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    cfg_t    cfg;
    sample_t sample_reg;
    logic    in_valid_reg;
    logic    out_valid_reg;
    result_t result_reg;
    result_t res;
    logic    res_valid;
    logic    advance;

    mssr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The held sample moves on when the output register is free or draining.
    assign advance  = in_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready = ~in_valid_reg | advance;

    mssr_seq #(
        .ERROR_WIDTH (ERROR_WIDTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (advance),
        .sample    (sample_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sample_reg.scan_address  <= scan_address;
            sample_reg.segment_lines <= segment_lines;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_valid;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            result_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign position       = result_reg.position;
    assign char_code      = result_reg.char_code;
    assign channel_number = result_reg.channel_number;
    assign frame_end      = result_reg.frame_end;
    assign error_total    = result_reg.error_total;

endmodule

>>> hw/rtl/mssr_cfg.sv
`timescale 1ns / 1ps

module mssr_cfg
    import mssr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic [CNT_W-1:0]    addr_confirm_reg;
    logic [CNT_W-1:0]    seg_confirm_reg;
    logic [SETTLE_W-1:0] settle_reg;
    logic [1:0]          reg_index;
    logic                wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel & penable & pwrite & pready;

    // Register writes complete in the access phase of a write transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_confirm_reg <= ADDR_CONFIRM_RST;
            seg_confirm_reg  <= SEG_CONFIRM_RST;
            settle_reg       <= SETTLE_RST;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_ADDR_CONFIRM: addr_confirm_reg <= pwdata[CNT_W-1:0];
                REG_SEG_CONFIRM:  seg_confirm_reg  <= pwdata[CNT_W-1:0];
                REG_SETTLE:       settle_reg       <= pwdata[SETTLE_W-1:0];
                default:          ;
            endcase
        end
    end

    // Read back; addresses past the register list read as zero.
    always_comb
    begin
        case (reg_index)
            REG_ADDR_CONFIRM: prdata = PDATA_W'(addr_confirm_reg);
            REG_SEG_CONFIRM:  prdata = PDATA_W'(seg_confirm_reg);
            REG_SETTLE:       prdata = PDATA_W'(settle_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.addr_confirm = addr_confirm_reg;
    assign cfg.seg_confirm  = seg_confirm_reg;
    assign cfg.settle       = settle_reg;

endmodule

>>> hw/rtl/mssr_seq.sv
`timescale 1ns / 1ps

module mssr_seq
    import mssr_pkg::*;
#(
    parameter int ERROR_WIDTH = ERROR_WIDTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step_en,
    input  sample_t sample,
    input  cfg_t    cfg,
    output logic    res_valid,
    output result_t res
);

    phase_t                 phase_reg, phase_next, phase_eff;
    step_t                  step_reg, step_next;
    logic [ADDR_W-1:0]      prev_addr_reg, prev_addr_next;
    logic [CNT_W-1:0]       addr_cnt_reg, addr_cnt_next;
    logic [SEG_W-1:0]       prev_segs_reg, prev_segs_next;
    logic [CNT_W-1:0]       seg_cnt_reg, seg_cnt_next;
    logic [SETTLE_W-1:0]    settle_reg, settle_next;
    logic [ERROR_WIDTH-1:0] error_reg, error_next;

    logic [CNT_W-1:0]    addr_cnt_upd;
    logic [CNT_W-1:0]    seg_cnt_upd;
    logic [SETTLE_W-1:0] settle_inc;
    logic                addr_done;
    logic                seg_done;
    logic                addr_wanted;
    logic                is_digit;
    logic [2:0]          chan_num;
    logic [1:0]          digit_pos;
    logic [31:0]         error_wide;

    // Unused phase codes act as waiting for the sync address.
    always_comb
    begin
        case (phase_reg)
            PH_SYNC, PH_DIG0, PH_DIG1, PH_DIG2, PH_CHAN: phase_eff = phase_reg;
            default:                                     phase_eff = PH_SYNC;
        endcase
    end

    // Debounce counters saturate at their top value.
    assign addr_cnt_upd = (sample.scan_address != prev_addr_reg) ? '0 :
                          (addr_cnt_reg == '1) ? addr_cnt_reg : addr_cnt_reg + CNT_W'(1);
    assign seg_cnt_upd  = (sample.segment_lines != prev_segs_reg) ? '0 :
                          (seg_cnt_reg == '1) ? seg_cnt_reg : seg_cnt_reg + CNT_W'(1);
    assign addr_done    = addr_cnt_upd >= need(cfg.addr_confirm);
    assign seg_done     = seg_cnt_upd >= need(cfg.seg_confirm);
    assign settle_inc   = settle_reg + SETTLE_W'(1);

    // Digit position and the address each digit phase expects.
    always_comb
    begin
        case (phase_eff)
            PH_DIG0:
            begin
                is_digit  = 1'b1;
                digit_pos = 2'd0;
            end
            PH_DIG1:
            begin
                is_digit  = 1'b1;
                digit_pos = 2'd1;
            end
            PH_DIG2:
            begin
                is_digit  = 1'b1;
                digit_pos = 2'd2;
            end
            default:
            begin
                is_digit  = 1'b0;
                digit_pos = 2'd0;
            end
        endcase
    end

    assign addr_wanted = (is_digit && sample.scan_address == ADDR_W'(digit_pos)) ||
                         (phase_eff == PH_CHAN && sample.scan_address == CHANNEL_ADDRESS);

    // Channel indicator: exactly one of lines a to d must be low.
    always_comb
    begin
        case (~sample.segment_lines[3:0])
            4'b0001: chan_num = 3'd1;
            4'b0010: chan_num = 3'd2;
            4'b0100: chan_num = 3'd3;
            4'b1000: chan_num = 3'd4;
            default: chan_num = 3'd0;
        endcase
    end

    // Next state for one sample.
    always_comb
    begin
        phase_next     = phase_eff;
        step_next      = step_reg;
        prev_addr_next = prev_addr_reg;
        addr_cnt_next  = addr_cnt_reg;
        prev_segs_next = prev_segs_reg;
        seg_cnt_next   = seg_cnt_reg;
        settle_next    = settle_reg;
        error_next     = error_reg;
        case (step_reg)
            STEP_SETTLE:
            begin
                settle_next = settle_inc;
                if (settle_inc >= cfg.settle)
                begin
                    step_next = STEP_SEGS;
                end
            end
            STEP_SEGS:
            begin
                prev_segs_next = sample.segment_lines;
                seg_cnt_next   = seg_cnt_upd;
                if (seg_done)
                begin
                    prev_segs_next = SEGS_IDLE;
                    seg_cnt_next   = '0;
                    step_next      = STEP_ADDR;
                    case (phase_eff)
                        PH_DIG0: phase_next = PH_DIG1;
                        PH_DIG1: phase_next = PH_DIG2;
                        PH_DIG2: phase_next = PH_CHAN;
                        PH_CHAN:
                        begin
                            if (chan_num != 3'd0)
                            begin
                                phase_next = PH_SYNC;
                            end
                            else if (error_reg != '1)
                            begin
                                error_next = error_reg + ERROR_WIDTH'(1);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default:
            begin
                // Confirm the scan address; an unused step code acts the same.
                step_next      = STEP_ADDR;
                prev_addr_next = sample.scan_address;
                addr_cnt_next  = addr_cnt_upd;
                if (addr_done)
                begin
                    prev_addr_next = ADDR_IDLE;
                    addr_cnt_next  = '0;
                    if (phase_eff == PH_SYNC)
                    begin
                        if (sample.scan_address == SYNC_ADDRESS)
                        begin
                            phase_next = PH_DIG0;
                        end
                    end
                    else if (addr_wanted)
                    begin
                        settle_next = '0;
                        step_next   = (cfg.settle == '0) ? STEP_SEGS : STEP_SETTLE;
                    end
                end
            end
        endcase
    end

    // Result of the current sample.
    assign error_wide = 32'(error_reg);

    always_comb
    begin
        res_valid          = 1'b0;
        res.position       = digit_pos;
        res.char_code      = '0;
        res.channel_number = 3'd0;
        res.frame_end      = 1'b0;
        res.error_total    = error_wide[ERROUT_W-1:0];
        if (step_reg == STEP_SEGS && seg_done)
        begin
            if (is_digit)
            begin
                res_valid     = 1'b1;
                res.char_code = decode_pattern(~sample.segment_lines);
            end
            else if (phase_eff == PH_CHAN && chan_num != 3'd0)
            begin
                res_valid          = 1'b1;
                res.position       = POS_CHANNEL;
                res.channel_number = chan_num;
                res.frame_end      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SYNC;
            step_reg      <= STEP_ADDR;
            prev_addr_reg <= ADDR_IDLE;
            addr_cnt_reg  <= '0;
            prev_segs_reg <= SEGS_IDLE;
            seg_cnt_reg   <= '0;
            settle_reg    <= '0;
            error_reg     <= '0;
        end
        else if (step_en)
        begin
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            prev_addr_reg <= prev_addr_next;
            addr_cnt_reg  <= addr_cnt_next;
            prev_segs_reg <= prev_segs_next;
            seg_cnt_reg   <= seg_cnt_next;
            settle_reg    <= settle_next;
            error_reg     <= error_next;
        end
    end

endmodule
